// ===== sv/bdn_pkg.sv =====
`timescale 1ns / 1ps

package bdn_pkg;

  // Fixed field widths.
  localparam int PIX_W      = 8;
  localparam int RUN_W      = 12;
  localparam int SUM_W      = 16;
  localparam int SUB_W      = 4;
  localparam int FACT_W     = 5;
  localparam int IWIDTH_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_FACTOR = 16;

  // Register values after reset.
  localparam logic [FACT_W-1:0]   RST_FACTOR    = 5'd1;
  localparam logic [IWIDTH_W-1:0] RST_ROW_WIDTH = 13'd640;

  // Cycles needed to recompute the derived configuration after a write.
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  // Entries of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FACTOR_X  = 2'd0,
    REG_FACTOR_Y  = 2'd1,
    REG_ROW_WIDTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             end_of_row;
  } pix_out_t;

endpackage

// ===== sv/bdn_ram.sv =====
`timescale 1ns / 1ps

module bdn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bdn_queue.sv =====
`timescale 1ns / 1ps

module bdn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== sv/bdn_front.sv =====
`timescale 1ns / 1ps

module bdn_front #(
  parameter int MAX_WIDTH = bdn_pkg::DEF_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH + 1),
  localparam int EW = CW + bdn_pkg::RUN_W + 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  input  bdn_pkg::pix_in_t            pix_data,
  input  logic                        hold,
  output logic                        pix_stall,
  input  logic [bdn_pkg::FACT_W-1:0]  factor_x,
  input  logic [bdn_pkg::FACT_W-1:0]  factor_y,
  input  logic [CW-1:0]               width,
  input  logic [CW-1:0]               used,
  output logic                        q_push,
  output logic [EW-1:0]               q_entry
);

  logic [CW-1:0]                col;
  logic [CW-1:0]                col_next;
  logic [bdn_pkg::SUB_W-1:0]    sub_col;
  logic [bdn_pkg::SUB_W-1:0]    sub_col_next;
  logic [bdn_pkg::SUB_W-1:0]    sub_row;
  logic [bdn_pkg::SUB_W-1:0]    sub_row_next;
  logic [bdn_pkg::RUN_W-1:0]    run_sum;
  logic [bdn_pkg::RUN_W-1:0]    run_sum_next;

  logic                         accept;
  logic                         block_end;
  logic [CW-1:0]                col0;
  logic [CW-1:0]                col_inc;
  logic [bdn_pkg::SUB_W-1:0]    sc0;
  logic [bdn_pkg::SUB_W-1:0]    sr0;
  logic [bdn_pkg::RUN_W-1:0]    rs0;
  logic [bdn_pkg::RUN_W-1:0]    run_inc;
  logic [bdn_pkg::FACT_W-1:0]   sc_inc;
  logic [bdn_pkg::FACT_W-1:0]   sr_inc;

  assign pix_stall = hold;
  assign accept    = pix_valid && !hold;
  assign q_push    = accept && block_end;

  always_comb begin
    // A frame start restarts position and sums before this pixel counts.
    col0    = pix_data.frame_start ? '0 : col;
    sc0     = pix_data.frame_start ? '0 : sub_col;
    sr0     = pix_data.frame_start ? '0 : sub_row;
    rs0     = pix_data.frame_start ? '0 : run_sum;
    col_inc = col0 + CW'(1);
    sc_inc  = {1'b0, sc0} + bdn_pkg::FACT_W'(1);
    sr_inc  = {1'b0, sr0} + bdn_pkg::FACT_W'(1);
    run_inc = rs0 + bdn_pkg::RUN_W'(pix_data.pixel);

    block_end    = 1'b0;
    col_next     = col_inc;
    sub_col_next = sc0;
    sub_row_next = sr0;
    run_sum_next = rs0;

    if (col0 < used) begin
      if (sc_inc >= factor_x) begin
        block_end    = 1'b1;
        sub_col_next = '0;
        run_sum_next = '0;
      end else begin
        sub_col_next = sc_inc[bdn_pkg::SUB_W-1:0];
        run_sum_next = run_inc;
      end
    end

    if (col_inc >= width) begin
      col_next     = '0;
      sub_col_next = '0;
      run_sum_next = '0;
      sub_row_next = (sr_inc >= factor_y) ? '0 : sr_inc[bdn_pkg::SUB_W-1:0];
    end

    // Entry: column, finished run sum, first row of group, last row of group.
    q_entry = {col0, run_inc, (sr0 == '0), (sr_inc == factor_y)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      sub_col <= '0;
      sub_row <= '0;
      run_sum <= '0;
    end else if (accept) begin
      col     <= col_next;
      sub_col <= sub_col_next;
      sub_row <= sub_row_next;
      run_sum <= run_sum_next;
    end
  end

endmodule

// ===== sv/bdn_back.sv =====
`timescale 1ns / 1ps

module bdn_back #(
  parameter int MAX_WIDTH  = bdn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = bdn_pkg::DEF_MAX_FACTOR,
  localparam int CW   = $clog2(MAX_WIDTH + 1),
  localparam int AW   = $clog2(MAX_WIDTH),
  localparam int EW   = CW + bdn_pkg::RUN_W + 2,
  localparam int SX   = CW + 4,
  localparam int RXW  = SX + 1,
  localparam int SXY  = bdn_pkg::SUM_W + 2 * $clog2(MAX_FACTOR),
  localparam int RXYW = SXY + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  logic [EW-1:0]        q_head,
  output logic                 q_pop,
  input  logic [RXW-1:0]       recip_x,
  input  logic [RXYW-1:0]      recip_xy,
  input  logic [CW-1:0]        out_cols,
  output logic                 avg_valid,
  input  logic                 avg_stall,
  output bdn_pkg::pix_out_t    avg_data
);

  localparam int RW = bdn_pkg::RUN_W;
  localparam int SW = bdn_pkg::SUM_W;

  logic             adv;

  logic             s1_valid;
  logic [CW+RXW-1:0] s1_prod;
  logic [RW-1:0]    s1_run;
  logic             s1_first;
  logic             s1_last;

  logic             s2_valid;
  logic [AW-1:0]    s2_addr;
  logic [RW-1:0]    s2_run;
  logic             s2_first;
  logic             s2_last;

  logic             s3_valid;
  logic [AW-1:0]    s3_addr;
  logic [RW-1:0]    s3_run;
  logic             s3_first;
  logic             s3_last;

  logic             pw_valid;
  logic [AW-1:0]    pw_addr;
  logic [SW-1:0]    pw_data;

  logic             s4_valid;
  logic [SW-1:0]    s4_sum;
  logic             s4_last;
  logic             s4_eor;

  logic [SW-1:0]    ram_q;
  logic [SW-1:0]    col_data;
  logic [SW-1:0]    sum;
  logic             eor;
  logic [SW+RXYW-1:0] s4_prod;

  // The whole pipeline moves together unless a result is held at the output.
  assign adv   = !avg_valid || !avg_stall;
  assign q_pop = adv && !q_empty;

  // The previous write has not reached the read port yet: forward it.
  assign col_data = (pw_valid && (pw_addr == s3_addr)) ? pw_data : ram_q;
  assign sum      = s3_first ? SW'(s3_run) : col_data + SW'(s3_run);
  assign eor      = ((CW'(s3_addr) + CW'(1)) == out_cols);
  assign s4_prod  = s4_sum * recip_xy;

  bdn_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WIDTH)
  ) u_col_sums (
    .clk   (clk),
    .we    (adv && s3_valid),
    .waddr (s3_addr),
    .wdata (sum),
    .re    (adv),
    .raddr (s2_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      pw_valid  <= 1'b0;
      avg_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      pw_valid  <= s3_valid;
      avg_valid <= s4_valid && s4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Output column is the block's column divided by the x factor.
      s1_prod  <= q_head[EW-1 -: CW] * recip_x;
      s1_run   <= q_head[2 +: RW];
      s1_first <= q_head[1];
      s1_last  <= q_head[0];

      s2_addr  <= s1_prod[SX +: AW];
      s2_run   <= s1_run;
      s2_first <= s1_first;
      s2_last  <= s1_last;

      s3_addr  <= s2_addr;
      s3_run   <= s2_run;
      s3_first <= s2_first;
      s3_last  <= s2_last;

      pw_addr  <= s3_addr;
      pw_data  <= sum;

      s4_sum   <= sum;
      s4_last  <= s3_last;
      s4_eor   <= eor;

      avg_data.out_pixel  <= s4_prod[SXY +: bdn_pkg::PIX_W];
      avg_data.end_of_row <= s4_eor;
    end
  end

endmodule

// ===== sv/box_downscale_by_n_unit.sv =====
`timescale 1ns / 1ps
// A block's last run passes through the queue, stages s1 to s4 and the output register.
// Throughput: one pixel per clock while pix_stall is low; the front and the column-sum
// pipeline each run at one per cycle unless the front holds or the output stalls.
// After reset and after every configuration write the pixel input stalls while the clamped
// factors, reciprocals, output column count and used column count are recomputed.
// Reset (rst, synchronous, active high) clears position counters, queue and pipeline valids.

module box_downscale_by_n_unit #(
  parameter int MAX_WIDTH  = bdn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = bdn_pkg::DEF_MAX_FACTOR
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  bdn_pkg::pix_in_t              pix_data,
  output logic                          avg_valid,
  input  logic                          avg_stall,
  output bdn_pkg::pix_out_t             avg_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdn_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Column positions need to hold the width itself; sum-store addresses do not.
  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int EW   = CW + bdn_pkg::RUN_W + 2;
  localparam int SX   = CW + 4;
  localparam int RXW  = SX + 1;
  localparam int XIW  = $clog2(MAX_FACTOR);
  localparam int XYD  = MAX_FACTOR * MAX_FACTOR;
  localparam int XYIW = $clog2(XYD);
  localparam int SXY  = bdn_pkg::SUM_W + 2 * XIW;
  localparam int RXYW = SXY + 1;
  localparam int FW   = bdn_pkg::FACT_W;

  // Configuration registers as written.
  logic [FW-1:0]                 factor_x;
  logic [FW-1:0]                 factor_y;
  logic [bdn_pkg::IWIDTH_W-1:0]  row_width;

  // Derived configuration, recomputed every cycle in a four-step chain:
  // clamp, reciprocal lookup, output column count, used column count.
  logic [FW-1:0]                 fx_c;
  logic [FW-1:0]                 fy_c;
  logic [CW-1:0]                 width_c;
  logic [XYIW-1:0]               xy_idx;
  logic [RXW-1:0]                recip_x;
  logic [RXYW-1:0]               recip_xy;
  logic [CW-1:0]                 out_cols;
  logic [CW-1:0]                 used;
  logic [2:0]                    settle_cnt;

  logic [FW-1:0]                 fx_clamp;
  logic [FW-1:0]                 fy_clamp;
  logic [31:0]                   w_ext;
  logic [CW-1:0]                 w_clamp;
  logic [2*FW-1:0]               xy_prod;
  logic [XIW-1:0]                x_idx;
  logic [CW+RXW-1:0]             cols_prod;
  logic [CW+FW-1:0]              used_prod;

  logic [RXW-1:0]                tab_x  [MAX_FACTOR];
  logic [RXYW-1:0]               tab_xy [XYD];

  logic                          cfg_write;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_empty;
  logic [EW-1:0]                 q_wdata;
  logic [EW-1:0]                 q_rdata;

  // Reciprocal tables: ceil(2^S / d). For the operand ranges used here the
  // product shifted right by S is exactly the truncated quotient.
  for (genvar gi = 0; gi < MAX_FACTOR; gi++) begin : g_tab_x
    localparam longint unsigned DIV   = gi + 1;
    localparam longint unsigned RECIP = ((64'd1 << SX) + DIV - 1) / DIV;
    assign tab_x[gi] = RXW'(RECIP);
  end

  for (genvar gi = 0; gi < XYD; gi++) begin : g_tab_xy
    localparam longint unsigned DIV   = gi + 1;
    localparam longint unsigned RECIP = ((64'd1 << SXY) + DIV - 1) / DIV;
    assign tab_xy[gi] = RXYW'(RECIP);
  end

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_x  <= bdn_pkg::RST_FACTOR;
      factor_y  <= bdn_pkg::RST_FACTOR;
      row_width <= bdn_pkg::RST_ROW_WIDTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bdn_pkg::REG_FACTOR_X:  factor_x  <= cfg_data[FW-1:0];
        bdn_pkg::REG_FACTOR_Y:  factor_y  <= cfg_data[FW-1:0];
        bdn_pkg::REG_ROW_WIDTH: row_width <= cfg_data[bdn_pkg::IWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // A factor of zero acts as one, and one above the maximum as the maximum.
  // The same holds for the width against its own limits.
  always_comb begin
    fx_clamp = (factor_x == '0) ? FW'(1) :
               (factor_x > FW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : factor_x;
    fy_clamp = (factor_y == '0) ? FW'(1) :
               (factor_y > FW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : factor_y;
    w_ext    = 32'(row_width);
    w_clamp  = (w_ext == '0) ? CW'(1) :
               (w_ext > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext[CW-1:0];
  end

  assign xy_prod   = fx_c * fy_c;
  assign x_idx     = XIW'(fx_c - FW'(1));
  assign cols_prod = width_c * recip_x;
  assign used_prod = out_cols * fx_c;

  always_ff @(posedge clk) begin
    fx_c     <= fx_clamp;
    fy_c     <= fy_clamp;
    width_c  <= w_clamp;
    xy_idx   <= XYIW'(xy_prod - (2*FW)'(1));
    recip_x  <= tab_x[x_idx];
    recip_xy <= tab_xy[xy_idx];
    out_cols <= cols_prod[SX +: CW];
    used     <= used_prod[CW-1:0];
  end

  // Pixels wait until the derived values reflect the latest registers.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle_cnt <= bdn_pkg::SETTLE_CYCLES;
    end else if (settle_cnt != '0) begin
      settle_cnt <= settle_cnt - 3'd1;
    end
  end

  // The front tracks position within the row and block and emits one queue
  // transaction per finished horizontal run. It holds whenever the queue is
  // full, so no run is ever lost; the back drains the queue independently.
  bdn_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .hold      ((settle_cnt != '0) || q_full),
    .pix_stall (pix_stall),
    .factor_x  (fx_c),
    .factor_y  (fy_c),
    .width     (width_c),
    .used      (used),
    .q_push    (q_push),
    .q_entry   (q_wdata)
  );

  bdn_queue #(
    .WIDTH (EW),
    .DEPTH (bdn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // The back finds the output column, accumulates into the column-sum store
  // and on the last row of a group divides the block sum into a pixel.
  bdn_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_rdata),
    .q_pop     (q_pop),
    .recip_x   (recip_x),
    .recip_xy  (recip_xy),
    .out_cols  (out_cols),
    .avg_valid (avg_valid),
    .avg_stall (avg_stall),
    .avg_data  (avg_data)
  );

  // The front must never hand a run to a queue that cannot take it.
  ap_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("run pushed into a full queue");

  // Right after a configuration write no pixel transaction may be taken.
  ap_stall_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> pix_stall)
    else $error("pixel accepted while configuration settles");

  ap_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue reports full and empty at once");

endmodule
